FILE: rtl/core/cmsg_pkg.sv
// Package for the chaotic map generator: constants, types, sine table and clamp functions.
`timescale 1ns / 1ps

package cmsg_pkg;

  localparam int FRAC_BITS  = 30;
  localparam int SINE_DEPTH = 256;
  localparam int TQ_BITS    = 30;

  localparam int VAL_W   = 31;
  localparam int GAIN_W  = 33;
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 31;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int IDX_W   = $clog2(SINE_DEPTH + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 33;

  localparam logic [63:0] ONE_Q        = 64'd1 << FRAC_BITS;
  localparam logic [63:0] HALF_Q       = ONE_Q >> 1;
  localparam logic [63:0] GAIN_DEF_LOG = ((64'd399999 << FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam logic [63:0] GAIN_MIN_LOG = (64'd37 << FRAC_BITS) / 64'd10;
  localparam logic [63:0] GAIN_MAX_LOG = ONE_Q << 2;
  localparam logic [63:0] HALF_PI_TQ   = 64'd1686629713;
  localparam logic [63:0] SINE_SCALE   = 64'(2 * SINE_DEPTH);

  localparam logic [VAL_W-1:0]  VAL_ONE   = VAL_W'(ONE_Q);
  localparam logic [VAL_W-1:0]  VAL_HALF  = VAL_W'(HALF_Q);
  localparam logic [GAIN_W-1:0] GAIN_DEF  = GAIN_W'(GAIN_DEF_LOG);
  localparam logic [GAIN_W-1:0] GAIN_MIN  = GAIN_W'(GAIN_MIN_LOG);
  localparam logic [GAIN_W-1:0] GAIN_MAX  = GAIN_W'(GAIN_MAX_LOG);
  localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(ONE_Q);
  localparam logic [GAIN_W-1:0] GAIN_HALF = GAIN_W'(HALF_Q);

  localparam logic [CFG_IDX_W-1:0] REG_MAP_SELECT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SEED_VALUE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAP_GAIN   = CFG_IDX_W'(2);

  localparam logic MAP_LOGISTIC = 1'b0;
  localparam logic MAP_SINE     = 1'b1;

  typedef logic [VAL_W-1:0] sine_tab_t [0:SINE_DEPTH];

  typedef struct packed {
    logic              map_select;
    logic [VAL_W-1:0]  seed_value;
    logic [GAIN_W-1:0] map_gain;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL1,
    ST_STEP2,
    ST_MUL2,
    ST_FIN
  } state_t;

  // Truncated Taylor series of sin(a), a in Q30, up to the x^17 term.
  function automatic logic [VAL_W-1:0] sine_entry(input logic [63:0] a);
    logic [63:0] a2;
    logic [63:0] term;
    longint      sum;
    a2   = (a * a) >> TQ_BITS;
    term = a;
    sum  = longint'(a);
    term = ((term * a2) >> TQ_BITS) / 64'd6;   sum = sum - longint'(term);
    term = ((term * a2) >> TQ_BITS) / 64'd20;  sum = sum + longint'(term);
    term = ((term * a2) >> TQ_BITS) / 64'd42;  sum = sum - longint'(term);
    term = ((term * a2) >> TQ_BITS) / 64'd72;  sum = sum + longint'(term);
    term = ((term * a2) >> TQ_BITS) / 64'd110; sum = sum - longint'(term);
    term = ((term * a2) >> TQ_BITS) / 64'd156; sum = sum + longint'(term);
    term = ((term * a2) >> TQ_BITS) / 64'd210; sum = sum - longint'(term);
    term = ((term * a2) >> TQ_BITS) / 64'd272; sum = sum + longint'(term);
    if (sum < 0) begin
      return '0;
    end
    if (sum > longint'(64'd1 << TQ_BITS)) begin
      return VAL_W'(64'd1 << TQ_BITS);
    end
    return VAL_W'(sum);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      t[i] = sine_entry((64'(i) * HALF_PI_TQ) / SINE_DEPTH);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  function automatic logic [VAL_W-1:0] clamp_seed(input logic [VAL_W-1:0] s);
    return (s > VAL_ONE) ? VAL_HALF : s;
  endfunction

  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] m,
                                                   input logic sel);
    if (sel == MAP_LOGISTIC) begin
      return (m < GAIN_MIN || m > GAIN_MAX) ? GAIN_DEF : m;
    end
    return (m > GAIN_ONE) ? GAIN_HALF : m;
  endfunction

endpackage

FILE: rtl/core/chaotic_map_sequence_generator.sv
// Top level of the chaotic map generator: configuration registers, sequencer and multiplier.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------
//   input   | in_valid / in_ready  | restart
//   output  | out_valid / out_ready| next_value (Q30)
//   config  | cfg_wr_en            | cfg_index, cfg_data
//
// An item is accepted in the idle state and its result enters the output register after
// two dependent passes through the one shared 33x31 multiplier, each an operand load
// state and a product state (PREP/MUL1, STEP2/MUL2), then ST_FIN writes the result.
// The input is not ready while an item is in work; a new one is taken only in idle.
// A finished result waits in the output register while the next item is accepted; that
// item then holds in ST_FIN until the register is free. rst is synchronous.
`timescale 1ns / 1ps

module chaotic_map_sequence_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [cmsg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cmsg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cmsg_pkg::VAL_W-1:0]      next_value
);
  import cmsg_pkg::*;

  cfg_t               cfg;
  logic               mul_load;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_select <= MAP_LOGISTIC;
      cfg.seed_value <= VAL_HALF;
      cfg.map_gain   <= GAIN_DEF;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MAP_SELECT: cfg.map_select <= cfg_data[0];
        REG_SEED_VALUE: cfg.seed_value <= cfg_data[VAL_W-1:0];
        REG_MAP_GAIN:   cfg.map_gain   <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cmsg_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .next_value (next_value),
    .mul_load   (mul_load),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .prod       (prod)
  );

  cmsg_mul u_mul (
    .clk  (clk),
    .load (mul_load),
    .a_in (mul_a),
    .b_in (mul_b),
    .prod (prod)
  );

endmodule

FILE: rtl/core/cmsg_mul.sv
// Shared registered multiplier used for every product of one map step.
`timescale 1ns / 1ps

module cmsg_mul (
  input  logic                          clk,
  input  logic                          load,
  input  logic [cmsg_pkg::MUL_A_W-1:0] a_in,
  input  logic [cmsg_pkg::MUL_B_W-1:0] b_in,
  output logic [cmsg_pkg::PROD_W-1:0]  prod
);
  import cmsg_pkg::*;

  logic [MUL_A_W-1:0] a;
  logic [MUL_B_W-1:0] b;

  always_ff @(posedge clk) begin
    if (load) begin
      a <= a_in;
      b <= b_in;
    end
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

FILE: rtl/core/cmsg_seq.sv
// Step sequencer and datapath registers of the chaotic map generator.
`timescale 1ns / 1ps

module cmsg_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  cmsg_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         restart,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cmsg_pkg::VAL_W-1:0]   next_value,
  output logic                         mul_load,
  output logic [cmsg_pkg::MUL_A_W-1:0] mul_a,
  output logic [cmsg_pkg::MUL_B_W-1:0] mul_b,
  input  logic [cmsg_pkg::PROD_W-1:0]  prod
);
  import cmsg_pkg::*;

  state_t state, state_next;

  logic [VAL_W-1:0]  cur;
  logic [GAIN_W-1:0] gain;
  logic [VAL_W-1:0]  s0;
  logic              down;

  logic [VAL_W-1:0]     x_c;
  logic [VAL_W-1:0]     u_c;
  logic [63:0]          p_c;
  logic [IDX_W-1:0]     idx_c;
  logic [FRAC_BITS-1:0] fr_c;
  logic [VAL_W-1:0]     s0_c;
  logic [VAL_W-1:0]     s1_c;
  logic [VAL_W-1:0]     diff_c;
  logic [GAIN_W-1:0]    gain_c;
  logic [PROD_W-1:0]    shr_c;
  logic [VAL_W-1:0]     s_c;
  logic [VAL_W-1:0]     nx_c;
  logic                 out_free;

  assign shr_c    = prod >> FRAC_BITS;
  assign out_free = !out_valid || out_ready;
  assign gain_c   = clamp_gain(gain, cfg.map_select);
  assign x_c      = (cur > VAL_ONE) ? VAL_HALF : cur;

  // Fold onto the rising quarter wave and split into table index and weight.
  always_comb begin
    if (x_c > VAL_HALF) begin
      u_c = VAL_ONE - x_c;
    end else begin
      u_c = x_c;
    end
    p_c = 64'(u_c) * SINE_SCALE;
    if ((p_c >> FRAC_BITS) >= 64'(SINE_DEPTH)) begin
      idx_c = IDX_W'(SINE_DEPTH);
      fr_c  = '0;
    end else begin
      idx_c = IDX_W'(p_c >> FRAC_BITS);
      fr_c  = p_c[FRAC_BITS-1:0];
    end
    s0_c = SINE_TAB[idx_c];
    if (idx_c < IDX_W'(SINE_DEPTH)) begin
      s1_c = SINE_TAB[idx_c + IDX_W'(1)];
    end else begin
      s1_c = s0_c;
    end
    diff_c = (s1_c >= s0_c) ? (s1_c - s0_c) : (s0_c - s1_c);
  end

  always_comb begin
    if (down) begin
      s_c = (s0 - VAL_W'(shr_c)) >> (TQ_BITS - FRAC_BITS);
    end else begin
      s_c = (s0 + VAL_W'(shr_c)) >> (TQ_BITS - FRAC_BITS);
    end
    if (shr_c > PROD_W'(VAL_ONE)) begin
      nx_c = VAL_ONE;
    end else begin
      nx_c = VAL_W'(shr_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mul_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        mul_load = 1'b1;
        if (cfg.map_select == MAP_LOGISTIC) begin
          mul_a = MUL_A_W'(gain_c);
          mul_b = MUL_B_W'(x_c);
        end else begin
          mul_a = MUL_A_W'(diff_c);
          mul_b = MUL_B_W'(fr_c);
        end
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        state_next = ST_STEP2;
      end
      ST_STEP2: begin
        mul_load = 1'b1;
        if (cfg.map_select == MAP_LOGISTIC) begin
          mul_a = MUL_A_W'(shr_c);
          mul_b = MUL_B_W'(VAL_ONE - cur);
        end else begin
          mul_a = MUL_A_W'(gain);
          mul_b = MUL_B_W'(s_c);
        end
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequence state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= VAL_HALF;
      gain      <= GAIN_DEF;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && restart) begin
            cur  <= clamp_seed(cfg.seed_value);
            gain <= cfg.map_gain;
          end
        end
        ST_PREP: begin
          gain <= gain_c;
          cur  <= x_c;
        end
        ST_FIN: begin
          if (out_free) begin
            cur <= nx_c;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      s0   <= s0_c;
      down <= (s1_c < s0_c);
    end
    if (state == ST_FIN && out_free) begin
      next_value <= nx_c;
    end
  end

endmodule
